[rtl/sms_pkg.sv]
// ----------------------------------------------------------------------------
// sms_pkg
// Shared types and codes of the synthesizer modulation source: operation
// codes, source modes, configuration register indexes and field widths.
// ----------------------------------------------------------------------------
package sms_pkg;

	// Fixed field widths of the ports
	localparam int OP_W      = 2;
	localparam int SVAL_W    = 18;
	localparam int NOTE_W    = 7;
	localparam int STEP_W    = 16;
	localparam int MODE_W    = 3;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 17;

	// Controller number of the mod wheel
	localparam logic [NOTE_W-1:0] MOD_WHEEL_NUMBER = 7'd1;

	typedef enum logic [OP_W-1:0] {
		OP_TICK        = 2'd0,
		OP_CONTROLLER  = 2'd1,
		OP_PRESSURE    = 2'd2,
		OP_VOICE_START = 2'd3
	} op_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_TIME       = 3'd0,
		MODE_VELOCITY   = 3'd1,
		MODE_INV_VEL    = 3'd2,
		MODE_KEY_SCALE  = 3'd3,
		MODE_MOD_WHEEL  = 3'd4,
		MODE_PRESSURE   = 3'd5,
		MODE_CONTROLLER = 3'd6,
		MODE_CONSTANT   = 3'd7
	} mode_t;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_MODE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CONTROLLER_SEL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CONSTANT_LEVEL = 2'd2;

	// Reset values of the configuration registers
	localparam logic [CFG_W-1:0]  CONSTANT_RESET = 17'd32768;
	localparam logic [NOTE_W-1:0] CTL_SEL_RESET  = 7'd1;

endpackage

[rtl/synth_modulation_source_top.sv]
// ----------------------------------------------------------------------------
// synth_modulation_source_top
// Per-voice modulation source in unsigned fixed point (ONE = 2^FRACTION_BITS).
// ----------------------------------------------------------------------------
// Sequencing: controller and pressure events and a voice start whose key scale is
// trivial (empty range, note at or outside the range) complete in ST_IDLE. A
// sample tick passes from ST_IDLE to ST_READ: the controller table RAM read is
// registered, and the selected value lands in the output register in ST_READ
// (the tick holds in the read state while the previous result has not been
// taken). A voice start with a note inside the key range goes through ST_DIV,
// where the restoring divider produces one key-scale quotient bit per cycle.
// The controller table needs no clearing pass after reset: per-entry valid
// bits make unwritten controllers read as zero. Configuration writes take
// effect at once.
module synth_modulation_source_top #(
	parameter int CONTROLLER_COUNT = 128,
	parameter int FRACTION_BITS    = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Configuration port
	input  logic                          cfg_write,
	input  logic [sms_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sms_pkg::CFG_W-1:0]     cfg_data,
	// Input channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [sms_pkg::OP_W-1:0]      operation,
	input  logic signed [sms_pkg::SVAL_W-1:0] event_value,
	input  logic [sms_pkg::NOTE_W-1:0]    event_controller,
	input  logic signed [sms_pkg::SVAL_W-1:0] voice_time,
	input  logic [sms_pkg::STEP_W-1:0]    voice_time_step,
	input  logic signed [sms_pkg::SVAL_W-1:0] velocity,
	input  logic [sms_pkg::NOTE_W-1:0]    note_number,
	input  logic [sms_pkg::NOTE_W-1:0]    lowest_note,
	input  logic [sms_pkg::NOTE_W-1:0]    highest_note,
	// Output channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [FRACTION_BITS:0]        mod_value
);
	import sms_pkg::*;

	localparam int LW   = FRACTION_BITS + 1;
	localparam int AW   = (CONTROLLER_COUNT > 1) ? $clog2(CONTROLLER_COUNT) : 1;
	localparam int CW   = (LW > SVAL_W) ? LW : SVAL_W;
	localparam int KW   = (LW > CFG_W) ? LW : CFG_W;
	localparam int SW   = ((LW > STEP_W) ? LW : STEP_W) + 1;
	localparam int CNTW = $clog2(FRACTION_BITS + 1);
	localparam logic [LW-1:0]   ONE      = {1'b1, {FRACTION_BITS{1'b0}}};
	localparam logic [CNTW-1:0] DIV_LAST = CNTW'(FRACTION_BITS - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_DIV
	} state_t;

	// Saturate a signed 18-bit value to 0..ONE
	function automatic logic [LW-1:0] clamp_level(input logic [SVAL_W-1:0] raw);
		logic [CW-1:0] v;
		v = CW'(raw[SVAL_W-2:0]);
		if (raw[SVAL_W-1]) begin
			return '0;
		end else if (v > CW'(ONE)) begin
			return ONE;
		end else begin
			return LW'(v);
		end
	endfunction

	// Map a controller number onto the table, saturating at the last entry
	function automatic logic [AW-1:0] table_index(input logic [NOTE_W-1:0] num);
		if ({1'b0, num} >= 8'(CONTROLLER_COUNT)) begin
			return AW'(CONTROLLER_COUNT - 1);
		end else begin
			return num[AW-1:0];
		end
	endfunction

	// Configuration registers
	logic [MODE_W-1:0] source_mode_q;
	logic [NOTE_W-1:0] ctl_select_q;
	logic [CFG_W-1:0]  constant_q;

	// Voice and event state
	logic [LW-1:0]     pressure_q;
	logic [LW-1:0]     velocity_q;
	logic [LW-1:0]     key_scale_q;
	logic [LW-1:0]     time_acc_q;
	logic [STEP_W-1:0] time_inc_q;

	// Sequencer, divider and output registers
	state_t                   state_q;
	logic [CNTW-1:0]          div_cnt_q;
	logic [NOTE_W-1:0]        div_rem_q;
	logic [NOTE_W-1:0]        divisor_q;
	logic [FRACTION_BITS-1:0] quot_q;
	logic                     out_valid_q;
	logic [LW-1:0]            mod_value_q;

	// Controller table
	logic [CONTROLLER_COUNT-1:0] ctl_valid_q;
	logic                        rd_valid_q;
	logic [LW-1:0]               ram_rdata;
	logic [AW-1:0]               ram_waddr;
	logic [AW-1:0]               ram_raddr;
	logic                        ram_we;

	logic          accept;
	op_t           op;
	logic [LW-1:0] ctl_level;
	logic [LW-1:0] sel_value;
	logic [KW-1:0] const_ext;
	logic [SW-1:0] time_sum;
	logic [LW-1:0] time_next;
	logic          out_free;
	logic [NOTE_W:0] div_trial;
	logic          div_take;

	assign op       = op_t'(operation);
	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign mod_value = mod_value_q;

	// Table write on controller events, read on ticks
	assign ram_we    = accept && (op == OP_CONTROLLER);
	assign ram_waddr = table_index(event_controller);
	assign ram_raddr = (mode_t'(source_mode_q) == MODE_MOD_WHEEL) ?
		table_index(MOD_WHEEL_NUMBER) : table_index(ctl_select_q);

	sms_ram #(
		.WIDTH(LW),
		.DEPTH(CONTROLLER_COUNT)
	) u_ctl_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(clamp_level(event_value)),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Unwritten controllers read as zero
	assign ctl_level = rd_valid_q ? ram_rdata : '0;

	// Source selection
	assign const_ext = KW'(constant_q);
	always_comb begin
		unique case (mode_t'(source_mode_q))
			MODE_TIME:       sel_value = time_acc_q;
			MODE_VELOCITY:   sel_value = velocity_q;
			MODE_INV_VEL:    sel_value = ONE - velocity_q;
			MODE_KEY_SCALE:  sel_value = key_scale_q;
			MODE_MOD_WHEEL:  sel_value = ctl_level;
			MODE_PRESSURE:   sel_value = pressure_q;
			MODE_CONTROLLER: sel_value = ctl_level;
			MODE_CONSTANT:   sel_value = (const_ext > KW'(ONE)) ? ONE : LW'(const_ext);
			default:         sel_value = '0;
		endcase
	end

	// Saturating voice time ramp
	assign time_sum  = SW'(time_acc_q) + SW'(time_inc_q);
	assign time_next = (time_sum > SW'(ONE)) ? ONE : LW'(time_sum);

	// Divider step: shift in a zero, subtract the divisor if it fits
	assign div_trial = {div_rem_q, 1'b0};
	assign div_take  = div_trial >= {1'b0, divisor_q};

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_mode_q <= MODE_MOD_WHEEL;
			ctl_select_q  <= CTL_SEL_RESET;
			constant_q    <= CONSTANT_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_SOURCE_MODE:    source_mode_q <= cfg_data[MODE_W-1:0];
				REG_CONTROLLER_SEL: ctl_select_q  <= cfg_data[NOTE_W-1:0];
				REG_CONSTANT_LEVEL: constant_q    <= cfg_data;
				default:            ;
			endcase
		end
	end

	// Controller valid bits and registered read valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_valid_q <= '0;
			rd_valid_q  <= 1'b0;
		end else begin
			rd_valid_q <= ctl_valid_q[ram_raddr];
			if (ram_we) begin
				ctl_valid_q[ram_waddr] <= 1'b1;
			end
		end
	end

	// Sequencer: state, voice state, divider and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			div_cnt_q   <= '0;
			div_rem_q   <= '0;
			divisor_q   <= '0;
			quot_q      <= '0;
			out_valid_q <= 1'b0;
			mod_value_q <= '0;
			pressure_q  <= '0;
			velocity_q  <= '0;
			key_scale_q <= '0;
			time_acc_q  <= '0;
			time_inc_q  <= '0;
		end else begin
			// Drop a result once it is taken, unless a tick refills the register
			if (out_valid_q && out_ready && state_q != ST_READ) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (op)
							OP_TICK: state_q <= ST_READ;
							OP_CONTROLLER: ;
							OP_PRESSURE: pressure_q <= clamp_level(event_value);
							OP_VOICE_START: begin
								time_acc_q <= clamp_level(voice_time);
								time_inc_q <= voice_time_step;
								velocity_q <= clamp_level(velocity);
								if (highest_note <= lowest_note || note_number <= lowest_note) begin
									key_scale_q <= '0;
								end else if (note_number >= highest_note) begin
									key_scale_q <= ONE;
								end else begin
									div_rem_q <= note_number - lowest_note;
									divisor_q <= highest_note - lowest_note;
									div_cnt_q <= '0;
									state_q   <= ST_DIV;
								end
							end
							default: ;
						endcase
					end
				end
				ST_READ: begin
					// Hold the tick until the output register is free
					if (out_free) begin
						out_valid_q <= 1'b1;
						mod_value_q <= sel_value;
						time_acc_q  <= time_next;
						state_q     <= ST_IDLE;
					end
				end
				ST_DIV: begin
					// One quotient bit per cycle
					div_rem_q <= div_take ? NOTE_W'(div_trial - {1'b0, divisor_q})
						: div_trial[NOTE_W-1:0];
					quot_q    <= {quot_q[FRACTION_BITS-2:0], div_take};
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == DIV_LAST) begin
						key_scale_q <= {1'b0, quot_q[FRACTION_BITS-2:0], div_take};
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Levels never leave 0..ONE
	assert property (@(posedge clk) disable iff (!arst_n) key_scale_q <= ONE)
		else $error("key scale level above one");
	assert property (@(posedge clk) disable iff (!arst_n) time_acc_q <= ONE)
		else $error("voice time above one");
	assert property (@(posedge clk) disable iff (!arst_n) out_valid_q |-> mod_value_q <= ONE)
		else $error("result above one");
	// A tick always passes through the table read state
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && op == OP_TICK) |=> (state_q == ST_READ && !in_ready))
		else $error("tick did not enter the read cycle");

endmodule

[rtl/sms_ram.sv]
// ----------------------------------------------------------------------------
// sms_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sms_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule
